// ===== design/bdlp_pkg.sv =====
// Shared types and constants for the five-button debouncer with long-press events.
// No dependencies; every other design file imports this package.
package bdlp_pkg;

  localparam int PIN_W           = 5;   // pin_levels width
  localparam int BTN_IDX_W       = 3;   // reported button index width
  localparam int DEB_W           = 8;   // debounce_ticks / agree counter width
  localparam int HOLD_W          = 16;  // long_press_ticks / hold counter width
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int NUM_BUTTONS_DEF = 5;

  localparam logic [DEB_W-1:0]  DEB_TICKS_RST  = DEB_W'(20);
  localparam logic [HOLD_W-1:0] LONG_TICKS_RST = HOLD_W'(1000);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_FETCH = 2'd1,
    REQ_INIT  = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TICKS   = 1'd0,
    CFG_LONG_PRESS_TICKS = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [PIN_W-1:0] pin_levels;
  } in_t;

  typedef struct packed {
    logic                 press_found;
    logic [BTN_IDX_W-1:0] press_button;
    logic                 long_found;
    logic [BTN_IDX_W-1:0] long_button;
  } out_t;

  // Per-button command for one processed beat
  typedef struct packed {
    logic tick;
    logic init;
    logic raw;        // 1 = pin reads pressed
    logic clr_press;
    logic clr_long;
  } btn_ctrl_t;

  typedef struct packed {
    logic press_pend;
    logic long_pend;
  } btn_stat_t;

endpackage

// ===== design/bdlp_button.sv =====
// Debounce and press / long-press tracking for a single button.
// Depends on bdlp_pkg.
module bdlp_button (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bdlp_pkg::DEB_W-1:0]  deb_ticks,
  input  logic [bdlp_pkg::HOLD_W-1:0] long_ticks,
  input  bdlp_pkg::btn_ctrl_t       ctrl,
  output bdlp_pkg::btn_stat_t       stat
);
  import bdlp_pkg::*;

  logic              cand_r, cand_nxt;
  logic              stable_r, stable_nxt;
  logic [DEB_W-1:0]  agree_r, agree_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              armed_r, armed_nxt;
  logic              long_done_r, long_done_nxt;
  logic              press_pend_r, press_pend_nxt;
  logic              long_pend_r, long_pend_nxt;

  always_comb begin
    cand_nxt       = cand_r;
    stable_nxt     = stable_r;
    agree_nxt      = agree_r;
    hold_nxt       = hold_r;
    armed_nxt      = armed_r;
    long_done_nxt  = long_done_r;
    press_pend_nxt = press_pend_r;
    long_pend_nxt  = long_pend_r;

    if (ctrl.init) begin
      cand_nxt       = ctrl.raw;
      stable_nxt     = ctrl.raw;
      agree_nxt      = '0;
      hold_nxt       = '0;
      armed_nxt      = ~ctrl.raw;
      long_done_nxt  = 1'b0;
      press_pend_nxt = 1'b0;
      long_pend_nxt  = 1'b0;
    end else if (ctrl.tick) begin
      if (ctrl.raw != cand_r) begin
        cand_nxt  = ctrl.raw;
        agree_nxt = '0;
      end else if (agree_r < deb_ticks) begin
        agree_nxt = agree_r + DEB_W'(1);
      end

      // new stable level
      if (agree_nxt >= deb_ticks && stable_r != cand_nxt) begin
        stable_nxt    = cand_nxt;
        hold_nxt      = '0;
        long_done_nxt = 1'b0;
        if (cand_nxt) begin
          if (armed_r) begin
            press_pend_nxt = 1'b1;
          end
        end else begin
          armed_nxt = 1'b1;
        end
      end

      if (stable_nxt && armed_nxt) begin
        if (hold_nxt < long_ticks) begin
          hold_nxt = hold_nxt + HOLD_W'(1);
        end
        if (hold_nxt >= long_ticks && !long_done_nxt) begin
          long_done_nxt = 1'b1;
          long_pend_nxt = 1'b1;
        end
      end
    end else begin
      if (ctrl.clr_press) begin
        press_pend_nxt = 1'b0;
      end
      if (ctrl.clr_long) begin
        long_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r       <= 1'b0;
      stable_r     <= 1'b0;
      agree_r      <= '0;
      hold_r       <= '0;
      armed_r      <= 1'b1;
      long_done_r  <= 1'b0;
      press_pend_r <= 1'b0;
      long_pend_r  <= 1'b0;
    end else begin
      cand_r       <= cand_nxt;
      stable_r     <= stable_nxt;
      agree_r      <= agree_nxt;
      hold_r       <= hold_nxt;
      armed_r      <= armed_nxt;
      long_done_r  <= long_done_nxt;
      press_pend_r <= press_pend_nxt;
      long_pend_r  <= long_pend_nxt;
    end
  end

  assign stat.press_pend = press_pend_r;
  assign stat.long_pend  = long_pend_r;

endmodule

// ===== design/button_debounce_long_press.sv =====
// Multi-button debouncer with press and long-press event latching.
// A fetch beat passes through the input register and then the result register.
// Throughput: one beat per cycle while in_stall is low; all buttons update in parallel.
// A fetch waits in the input register only while the result register is full and stalled.
// Reset (synchronous, rst_n low): registers to 20 / 1000, all buttons released and armed,
// no events pending, both pipeline registers empty.
module button_debounce_long_press #(
  parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bdlp_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bdlp_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bdlp_pkg::*;

  logic [DEB_W-1:0]  deb_ticks_r;
  logic [HOLD_W-1:0] long_ticks_r;

  logic    s1_valid_r;
  in_t     s1_data_r;
  logic    s1_fire;
  logic    s1_is_tick, s1_is_fetch, s1_is_init;
  logic    out_free;

  logic    out_valid_r;
  out_t    out_data_r, out_data_nxt;

  logic [NUM_BUTTONS-1:0] press_pend, long_pend;
  logic [NUM_BUTTONS-1:0] clr_press, clr_long;
  logic [NUM_BUTTONS-1:0] raw;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_ticks_r  <= DEB_TICKS_RST;
      long_ticks_r <= LONG_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE_TICKS:   deb_ticks_r  <= cfg_data[DEB_W-1:0];
        CFG_LONG_PRESS_TICKS: long_ticks_r <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  assign s1_is_tick  = (s1_data_r.req_type == REQ_TICK);
  assign s1_is_fetch = (s1_data_r.req_type == REQ_FETCH);
  assign s1_is_init  = (s1_data_r.req_type == REQ_INIT);
  assign out_free    = !out_valid_r || !out_stall;
  assign s1_fire     = s1_valid_r && (!s1_is_fetch || out_free);
  assign in_stall    = s1_valid_r && !s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // ---------------- per-button state ----------------
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    btn_ctrl_t ctrl;
    btn_stat_t stat;

    // buttons past the pin field read as pressed
    if (i < PIN_W) begin : g_pin
      assign raw[i] = ~s1_data_r.pin_levels[i];
    end else begin : g_nopin
      assign raw[i] = 1'b1;
    end

    assign ctrl.tick      = s1_fire && s1_is_tick;
    assign ctrl.init      = s1_fire && s1_is_init;
    assign ctrl.raw       = raw[i];
    assign ctrl.clr_press = s1_fire && s1_is_fetch && clr_press[i];
    assign ctrl.clr_long  = s1_fire && s1_is_fetch && clr_long[i];

    bdlp_button u_button (
      .clk        (clk),
      .rst_n      (rst_n),
      .deb_ticks  (deb_ticks_r),
      .long_ticks (long_ticks_r),
      .ctrl       (ctrl),
      .stat       (stat)
    );

    assign press_pend[i] = stat.press_pend;
    assign long_pend[i]  = stat.long_pend;
  end

  // ---------------- fetch: lowest pending index ----------------
  always_comb begin
    out_data_nxt = '0;
    clr_press    = '0;
    clr_long     = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (press_pend[i] && !out_data_nxt.press_found) begin
        out_data_nxt.press_found  = 1'b1;
        out_data_nxt.press_button = BTN_IDX_W'(i);
        clr_press[i]              = 1'b1;
      end
      if (long_pend[i] && !out_data_nxt.long_found) begin
        out_data_nxt.long_found  = 1'b1;
        out_data_nxt.long_button = BTN_IDX_W'(i);
        clr_long[i]              = 1'b1;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_is_fetch) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_is_fetch) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_is_fetch && out_valid_r && out_stall))
    else $error("input stalled without a blocked fetch");

  a_fetch_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_is_fetch) |=> out_valid_r)
    else $error("fetch did not load the result register");

  a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !(s1_fire && s1_is_fetch)) |=> !out_valid_r)
    else $error("result beat repeated or invented");

  a_single_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(clr_press) && $onehot0(clr_long))
    else $error("more than one pending event cleared per fetch");

endmodule

// ===== test/tb_button_debounce_long_press.sv =====
// Testbench for button_debounce_long_press: directed and random tick/fetch/init beats
// checked against a predictor kept in step with every accepted beat.
// Depends on bdlp_pkg (payload structs, request and register codes, reset values).
module tb_button_debounce_long_press;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  localparam int              NB           = NUM_BUTTONS_DEF;
  localparam logic [1:0]      REQ_UNUSED   = 2'd3;   // undefined request, must be ignored
  localparam int              DRAIN_CYCLES = 6;
  localparam int              STALL_LIMIT  = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  button_debounce_long_press uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [DEB_W-1:0]  deb_limit;
  logic [HOLD_W-1:0] hold_limit;
  logic [NB-1:0]     cand_lvl, stab_lvl, armed, long_fired, press_pend, long_pend;
  logic [DEB_W-1:0]  agree_cnt [NB];
  logic [HOLD_W-1:0] hold_cnt [NB];

  out_t        fetch_reports [$];
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;     // no gaps on either side while set
  logic [PIN_W-1:0] pins_now = '1;

  function automatic logic pin_held(logic [PIN_W-1:0] pins, int b);
    return (b < PIN_W) ? ~pins[b] : 1'b1;
  endfunction

  function automatic void clear_buttons();
    cand_lvl   = '0;
    stab_lvl   = '0;
    long_fired = '0;
    press_pend = '0;
    long_pend  = '0;
    for (int b = 0; b < NB; b++) begin
      agree_cnt[b] = '0;
      hold_cnt[b]  = '0;
    end
  endfunction

  function automatic void debounce_tick(logic [PIN_W-1:0] pins);
    logic raw;
    for (int b = 0; b < NB; b++) begin
      raw = pin_held(pins, b);
      if (raw != cand_lvl[b]) begin
        cand_lvl[b]  = raw;
        agree_cnt[b] = '0;
      end else if (agree_cnt[b] < deb_limit) begin
        agree_cnt[b]++;
      end
      if (agree_cnt[b] >= deb_limit && stab_lvl[b] != cand_lvl[b]) begin
        stab_lvl[b]   = cand_lvl[b];
        hold_cnt[b]   = '0;
        long_fired[b] = 1'b0;
        if (stab_lvl[b]) begin
          if (armed[b]) press_pend[b] = 1'b1;
        end else begin
          armed[b] = 1'b1;
        end
      end
      if (stab_lvl[b] && armed[b]) begin
        if (hold_cnt[b] < hold_limit) hold_cnt[b]++;
        if (hold_cnt[b] >= hold_limit && !long_fired[b]) begin
          long_fired[b] = 1'b1;
          long_pend[b]  = 1'b1;
        end
      end
    end
  endfunction

  function automatic void resample_pins(logic [PIN_W-1:0] pins);
    clear_buttons();
    for (int b = 0; b < NB; b++) begin
      stab_lvl[b] = pin_held(pins, b);
      cand_lvl[b] = stab_lvl[b];
      armed[b]    = ~stab_lvl[b];
    end
  endfunction

  // lowest-index pending press and long event, each cleared on delivery
  function automatic out_t deliver_events();
    out_t rep;
    bit   got_press, got_long;
    rep       = '0;
    got_press = 1'b0;
    got_long  = 1'b0;
    for (int b = 0; b < NB; b++) begin
      if (!got_press && press_pend[b]) begin
        press_pend[b]    = 1'b0;
        rep.press_found  = 1'b1;
        rep.press_button = BTN_IDX_W'(b);
        got_press        = 1'b1;
      end
      if (!got_long && long_pend[b]) begin
        long_pend[b]    = 1'b0;
        rep.long_found  = 1'b1;
        rep.long_button = BTN_IDX_W'(b);
        got_long        = 1'b1;
      end
    end
    return rep;
  endfunction

  function automatic void apply_beat(in_t beat);
    case (beat.req_type)
      REQ_TICK:  debounce_tick(beat.pin_levels);
      REQ_FETCH: fetch_reports.push_back(deliver_events());
      REQ_INIT:  resample_pins(beat.pin_levels);
      default: ;
    endcase
  endfunction

  function automatic in_t beat_of(logic [1:0] kind, logic [PIN_W-1:0] pins);
    in_t beat;
    beat.req_type   = kind;
    beat.pin_levels = pins;
    return beat;
  endfunction

  function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // Result side: random stall, compare each accepted beat with the oldest report
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fetch_reports.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data);
        errors++;
      end else begin
        want = fetch_reports.pop_front();
        check_field("press_found", want.press_found, out_data.press_found);
        check_field("press_button", want.press_button, out_data.press_button);
        check_field("long_found", want.long_found, out_data.long_found);
        check_field("long_button", want.long_button, out_data.long_button);
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_button_debounce_long_press: FAIL");
        $finish;
      end
    end
  end

  task automatic send_beat(input in_t beat);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_beat(beat);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fetch_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] lng);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DEBOUNCE_TICKS;
    cfg_data  <= CFG_DATA_W'(deb);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    deb_limit = deb;
    cfg_index <= CFG_LONG_PRESS_TICKS;
    cfg_data  <= lng;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hold_limit = lng;
    cfg_valid <= 1'b0;
  endtask

  // Reset values: empty fetch, ignored request, then a press settling after 20 ticks
  task automatic test_reset_values();
    send_beat(beat_of(REQ_FETCH, 5'b00000));
    send_beat(beat_of(REQ_UNUSED, 5'b00000));
    repeat (21) send_beat(beat_of(REQ_TICK, 5'b11101));
    send_beat(beat_of(REQ_FETCH, 5'b11111));
  endtask

  // Zero counts: presses and long events land on the same tick; init disarms held keys
  task automatic test_instant_events();
    set_timing('0, '0);
    send_beat(beat_of(REQ_TICK, 5'b11110));
    send_beat(beat_of(REQ_TICK, 5'b01110));
    send_beat(beat_of(REQ_FETCH, 5'b10101));
    send_beat(beat_of(REQ_FETCH, 5'b01010));
    send_beat(beat_of(REQ_FETCH, 5'b11111));
    send_beat(beat_of(REQ_TICK, 5'b11111));
    send_beat(beat_of(REQ_INIT, 5'b00000));
    send_beat(beat_of(REQ_TICK, 5'b00000));
    send_beat(beat_of(REQ_FETCH, 5'b00000));
    send_beat(beat_of(REQ_TICK, 5'b11111));
    send_beat(beat_of(REQ_TICK, 5'b10101));
    send_beat(beat_of(REQ_UNUSED, 5'b11111));
    send_beat(beat_of(REQ_FETCH, 5'b00000));
    send_beat(beat_of(REQ_FETCH, 5'b00000));
    send_beat(beat_of(REQ_FETCH, 5'b00000));
  endtask

  // Episodes of held pin patterns; some end before the level settles. Glitch ticks,
  // fetches, inits and undefined requests are mixed in.
  task automatic test_random_phase(input int n_items, input logic [DEB_W-1:0] deb,
                                   input logic [HOLD_W-1:0] lng, input bit quiet_run);
    int sent, hold, ticks, span, roll;
    set_timing(deb, lng);
    steady = quiet_run;
    sent   = 0;
    span   = (lng > 16'd30) ? 30 : int'(lng);
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) pins_now = PIN_W'($urandom);
      else pins_now = pins_now ^ (PIN_W'(1) << $urandom_range(PIN_W - 1));
      if ($urandom_range(3) == 0) hold = $urandom_range(deb);
      else hold = int'(deb) + 1 + $urandom_range(span + 2);
      ticks = 0;
      while (ticks < hold) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_beat(beat_of(REQ_UNUSED, PIN_W'($urandom)));
        end else begin
          if (roll < 6) begin
            send_beat(beat_of(REQ_TICK, pins_now ^ PIN_W'($urandom)));
          end else if (roll < 8) begin
            pins_now = PIN_W'($urandom);
            send_beat(beat_of(REQ_INIT, pins_now));
          end else if (roll < 26) begin
            send_beat(beat_of(REQ_FETCH, PIN_W'($urandom)));
          end else begin
            send_beat(beat_of(REQ_TICK, pins_now));
            ticks++;
          end
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    deb_limit  = DEB_TICKS_RST;
    hold_limit = LONG_TICKS_RST;
    clear_buttons();
    armed = '1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_instant_events();
    test_random_phase(50, 8'd0, 16'd0, 1'b0);
    test_random_phase(50, 8'd1, 16'd2, 1'b0);
    test_random_phase(50, 8'd3, 16'd10, 1'b1);
    test_random_phase(50, 8'd2, 16'd0, 1'b0);
    test_random_phase(50, 8'd0, 16'd6, 1'b0);
    test_random_phase(50, DEB_W'($urandom_range(5)), HOLD_W'($urandom_range(20)), 1'b0);
    test_random_phase(50, 8'd4, 16'd25, 1'b0);
    // one long episode runs at the largest debounce and long-press counts
    test_random_phase(20, 8'hFF, 16'hFFFF, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("tb_button_debounce_long_press: PASS");
    end else begin
      $display("tb_button_debounce_long_press: FAIL");
    end
    $finish;
  end

endmodule
